@@ hw/rtl/ssps_pkg.sv @@
// shared types and constants of the stepper step pulse sequencer
// used by ssps_core, stepper_step_pulse_sequencer, ssps_pin_checker and testbench; no dependencies
package ssps_pkg;

    // register indexes of the configuration channel
    localparam int unsigned CfgIndexWidth = 3;
    localparam logic [CfgIndexWidth-1:0] REG_MICROSTEPS_PER_STEP = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_PULSE_HIGH_TICKS    = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_PULSE_LOW_TICKS     = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_DIR_SETUP_TICKS     = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_ENABLE_LEAD_TICKS   = 3'd4;
    localparam logic [CfgIndexWidth-1:0] REG_GROUP_GAP_TICKS     = 3'd5;
    localparam logic [CfgIndexWidth-1:0] REG_TAIL_TICKS          = 3'd6;

    localparam int unsigned CfgDataWidth = 16;
    localparam int unsigned CountWidth   = 32;

    // register reset values
    localparam logic [7:0]  RST_MICROSTEPS_PER_STEP = 8'd100;
    localparam logic [15:0] RST_PULSE_HIGH_TICKS    = 16'd4;
    localparam logic [15:0] RST_PULSE_LOW_TICKS     = 16'd4;
    localparam logic [15:0] RST_DIR_SETUP_TICKS     = 16'd6;
    localparam logic [15:0] RST_ENABLE_LEAD_TICKS   = 16'd5;
    localparam logic [15:0] RST_GROUP_GAP_TICKS     = 16'd1500;
    localparam logic [15:0] RST_TAIL_TICKS          = 16'd5;

    // input item kinds
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_MOVE = 1'b1;

    typedef enum logic [6:0] {
        PH_IDLE = 7'b0000001,
        PH_DIR  = 7'b0000010,
        PH_LEAD = 7'b0000100,
        PH_HIGH = 7'b0001000,
        PH_LOW  = 7'b0010000,
        PH_GAP  = 7'b0100000,
        PH_TAIL = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [7:0]  microsteps_per_step;
        logic [15:0] pulse_high_ticks;
        logic [15:0] pulse_low_ticks;
        logic [15:0] dir_setup_ticks;
        logic [15:0] enable_lead_ticks;
        logic [15:0] group_gap_ticks;
        logic [15:0] tail_ticks;
    } cfg_t;

    typedef struct packed {
        logic start_rejected;
        logic busy_res;
        logic dir_level;
        logic enable_level;
        logic step_level;
    } res_t;

    function automatic logic [15:0] at_least_one16(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

endpackage

@@ hw/rtl/ssps_core.sv @@
// sequencer state and next-state logic for one item per cycle
// depends on ssps_pkg
module ssps_core
    import ssps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  item_en,
    input  logic                  opcode,
    input  logic                  direction,
    input  logic [CountWidth-1:0] microstep_count,
    input  cfg_t                  cfg,
    output res_t                  res
);

    phase_t                phase_reg, phase_next;
    logic [15:0]           wait_reg, wait_next;
    logic [CountWidth-1:0] remain_reg, remain_next;
    logic [7:0]            pulses_reg, pulses_next;
    logic                  full_reg, full_next;
    logic                  step_reg, step_next;
    logic                  enable_reg, enable_next;
    logic                  dir_reg, dir_next;

    logic                  rejected;
    logic                  do_pause, do_group, do_high;
    logic [15:0]           wait_dec;
    logic [7:0]            pulses_dec;
    logic [15:0]           pause_len;
    logic [7:0]            group_size;
    logic [7:0]            take;

    always_comb begin
        phase_next  = phase_reg;
        wait_next   = wait_reg;
        remain_next = remain_reg;
        pulses_next = pulses_reg;
        full_next   = full_reg;
        step_next   = step_reg;
        enable_next = enable_reg;
        dir_next    = dir_reg;
        rejected    = 1'b0;
        do_pause    = 1'b0;
        do_group    = 1'b0;
        do_high     = 1'b0;
        wait_dec    = (wait_reg == 16'd0) ? 16'd0 : wait_reg - 16'd1;
        pulses_dec  = (pulses_reg == 8'd0) ? 8'd0 : pulses_reg - 8'd1;
        pause_len   = 16'd0;
        group_size  = (cfg.microsteps_per_step == 8'd0) ? 8'd1 : cfg.microsteps_per_step;
        take        = 8'd0;

        if (item_en) begin
            if (opcode == OP_TICK) begin
                if (phase_reg != PH_IDLE) begin
                    wait_next = wait_dec;
                    if (wait_dec == 16'd0) begin
                        case (phase_reg)
                            PH_DIR, PH_GAP, PH_TAIL: begin
                                do_group = 1'b1;
                            end
                            PH_LEAD: begin
                                do_high = 1'b1;
                            end
                            PH_HIGH: begin
                                step_next  = 1'b0;
                                phase_next = PH_LOW;
                                wait_next  = at_least_one16(cfg.pulse_low_ticks);
                            end
                            PH_LOW: begin
                                pulses_next = pulses_dec;
                                if (pulses_dec != 8'd0) begin
                                    do_high = 1'b1;
                                end else begin
                                    do_pause = 1'b1;
                                end
                            end
                            default: begin
                                phase_next = PH_IDLE;
                                wait_next  = 16'd0;
                            end
                        endcase
                    end
                end
            end else if (phase_reg != PH_IDLE) begin
                rejected = 1'b1;
            end else begin
                dir_next    = direction;
                remain_next = microstep_count;
                pulses_next = 8'd0;
                full_next   = 1'b0;
                if (cfg.dir_setup_ticks == 16'd0) begin
                    do_group = 1'b1;
                end else begin
                    phase_next = PH_DIR;
                    wait_next  = cfg.dir_setup_ticks;
                end
            end
        end

        // pause after a group, zero length falls through to the next group
        if (do_pause) begin
            enable_next = 1'b0;
            pause_len   = full_next ? cfg.group_gap_ticks : cfg.tail_ticks;
            if (pause_len == 16'd0) begin
                do_group = 1'b1;
            end else begin
                phase_next = full_next ? PH_GAP : PH_TAIL;
                wait_next  = pause_len;
            end
        end

        if (do_group) begin
            if (remain_next == '0) begin
                phase_next = PH_IDLE;
                wait_next  = 16'd0;
            end else begin
                full_next   = (remain_next >= CountWidth'(group_size));
                // a partial group is below group_size, so it fits in 8 bits
                take        = full_next ? group_size : remain_next[7:0];
                pulses_next = take;
                remain_next = remain_next - CountWidth'(take);
                enable_next = 1'b1;
                if (cfg.enable_lead_ticks == 16'd0) begin
                    do_high = 1'b1;
                end else begin
                    phase_next = PH_LEAD;
                    wait_next  = cfg.enable_lead_ticks;
                end
            end
        end

        if (do_high) begin
            step_next  = 1'b1;
            phase_next = PH_HIGH;
            wait_next  = at_least_one16(cfg.pulse_high_ticks);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            wait_reg   <= 16'd0;
            remain_reg <= '0;
            pulses_reg <= 8'd0;
            full_reg   <= 1'b0;
            step_reg   <= 1'b0;
            enable_reg <= 1'b0;
            dir_reg    <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            wait_reg   <= wait_next;
            remain_reg <= remain_next;
            pulses_reg <= pulses_next;
            full_reg   <= full_next;
            step_reg   <= step_next;
            enable_reg <= enable_next;
            dir_reg    <= dir_next;
        end
    end

    always_comb begin
        res.step_level     = step_next;
        res.enable_level   = enable_next;
        res.dir_level      = dir_next;
        res.busy_res       = (phase_next != PH_IDLE);
        res.start_rejected = rejected;
    end

    // every active phase waits at least one tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_IDLE) |-> (wait_reg != 16'd0))
        else $error("active phase with zero wait");

    // step pin is high only while in the high phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg |-> (phase_reg == PH_HIGH))
        else $error("step pin high outside high phase");

    // enable is held through lead, high and low
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((phase_reg == PH_LEAD) || (phase_reg == PH_HIGH) || (phase_reg == PH_LOW))
        |-> enable_reg)
        else $error("enable low inside a group");

    // a rejected move leaves the direction pin alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        (item_en && rejected) |=> (dir_reg == $past(dir_reg)))
        else $error("rejected move changed direction");

endmodule

@@ hw/rtl/stepper_step_pulse_sequencer.sv @@
// the result of an input transfer is registered and shows on the master side in the next cycle
// throughput: one item per cycle unless the master side stalls; the next-state
// logic of ssps_core sits between the sequencer registers and the result register
// s_tready stays high while the result register is empty or being drained
// reset (aresetn low, synchronous): sequencer idle, pins low, registers to defaults
// top level: configuration registers and output register; depends on ssps_pkg, ssps_core
module stepper_step_pulse_sequencer
    import ssps_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [39:0]              s_tdata,   // direction, microstep_count, zero fill
    input  logic                     s_tuser,   // opcode
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [7:0]               m_tdata,   // step_level, enable_level, dir_level,
                                                // busy_res, start_rejected, zero fill
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data
);

    cfg_t cfg_reg;
    res_t res;
    res_t res_reg;
    logic m_valid_reg;
    logic in_xfer;

    assign s_tready  = !m_valid_reg || m_tready;
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.microsteps_per_step <= RST_MICROSTEPS_PER_STEP;
            cfg_reg.pulse_high_ticks    <= RST_PULSE_HIGH_TICKS;
            cfg_reg.pulse_low_ticks     <= RST_PULSE_LOW_TICKS;
            cfg_reg.dir_setup_ticks     <= RST_DIR_SETUP_TICKS;
            cfg_reg.enable_lead_ticks   <= RST_ENABLE_LEAD_TICKS;
            cfg_reg.group_gap_ticks     <= RST_GROUP_GAP_TICKS;
            cfg_reg.tail_ticks          <= RST_TAIL_TICKS;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_MICROSTEPS_PER_STEP: cfg_reg.microsteps_per_step <= cfg_data[7:0];
                REG_PULSE_HIGH_TICKS:    cfg_reg.pulse_high_ticks    <= cfg_data;
                REG_PULSE_LOW_TICKS:     cfg_reg.pulse_low_ticks     <= cfg_data;
                REG_DIR_SETUP_TICKS:     cfg_reg.dir_setup_ticks     <= cfg_data;
                REG_ENABLE_LEAD_TICKS:   cfg_reg.enable_lead_ticks   <= cfg_data;
                REG_GROUP_GAP_TICKS:     cfg_reg.group_gap_ticks     <= cfg_data;
                REG_TAIL_TICKS:          cfg_reg.tail_ticks          <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    ssps_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .item_en         (in_xfer),
        .opcode          (s_tuser),
        .direction       (s_tdata[0]),
        .microstep_count (s_tdata[32:1]),
        .cfg             (cfg_reg),
        .res             (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload needs no reset
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, res_reg};

endmodule

@@ dv/ssps_pin_checker.sv @@
// checker for the stepper step pulse sequencer: watches the stream and configuration
// transfers, predicts the pin levels of every input item and compares the results
// depends on ssps_pkg
module ssps_pin_checker
    import ssps_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [39:0]              s_tdata,   // direction, microstep_count, zero fill
    input  logic                     s_tuser,   // opcode
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [7:0]               m_tdata,   // step_level, enable_level, dir_level,
                                                // busy_res, start_rejected, zero fill
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data,
    output int unsigned              fail_count,
    output int unsigned              results_due,
    output logic                     seq_busy
);
    timeunit 1ns;
    timeprecision 1ps;

    cfg_t        regs;
    phase_t      ph;
    logic [15:0] wait_cnt;
    logic [31:0] steps_left;
    logic [7:0]  pulses_left;
    logic        full_group;
    logic        step_pin;
    logic        en_pin;
    logic        dir_pin;

    res_t        pin_levels_q[$];
    int unsigned mismatches = 0;
    string       res_field[5] = '{"step_level", "enable_level", "dir_level",
                                  "busy_res", "start_rejected"};

    function automatic void begin_high();
        step_pin = 1'b1;
        ph       = PH_HIGH;
        wait_cnt = (regs.pulse_high_ticks == 16'd0) ? 16'd1 : regs.pulse_high_ticks;
    endfunction

    function automatic void begin_group();
        logic [7:0]  size;
        logic [31:0] take;
        size = (regs.microsteps_per_step == 8'd0) ? 8'd1 : regs.microsteps_per_step;
        if (steps_left == 32'd0) begin
            ph       = PH_IDLE;
            wait_cnt = 16'd0;
            return;
        end
        full_group  = (steps_left >= 32'(size));
        take        = full_group ? 32'(size) : steps_left;
        pulses_left = take[7:0];
        steps_left  = steps_left - take;
        en_pin      = 1'b1;
        if (regs.enable_lead_ticks == 16'd0) begin
            begin_high();
        end else begin
            ph       = PH_LEAD;
            wait_cnt = regs.enable_lead_ticks;
        end
    endfunction

    // pin levels after one input item: a tick advances time, a move starts a sequence
    function automatic res_t predict_pins(input logic op, input logic dir,
                                          input logic [31:0] cnt);
        res_t        r;
        logic        refused;
        logic [15:0] pause;
        refused = 1'b0;
        if (op == OP_TICK) begin
            if (ph != PH_IDLE) begin
                if (wait_cnt != 16'd0) wait_cnt--;
                if (wait_cnt == 16'd0) begin
                    case (ph)
                        PH_DIR, PH_GAP, PH_TAIL: begin_group();
                        PH_LEAD: begin_high();
                        PH_HIGH: begin
                            step_pin = 1'b0;
                            ph       = PH_LOW;
                            wait_cnt = (regs.pulse_low_ticks == 16'd0) ? 16'd1
                                                                       : regs.pulse_low_ticks;
                        end
                        PH_LOW: begin
                            if (pulses_left != 8'd0) pulses_left--;
                            if (pulses_left != 8'd0) begin
                                begin_high();
                            end else begin
                                // group done: enable drops, then gap (full group) or tail
                                en_pin = 1'b0;
                                pause  = full_group ? regs.group_gap_ticks : regs.tail_ticks;
                                if (pause == 16'd0) begin
                                    begin_group();
                                end else begin
                                    ph       = full_group ? PH_GAP : PH_TAIL;
                                    wait_cnt = pause;
                                end
                            end
                        end
                        default: begin
                            ph       = PH_IDLE;
                            wait_cnt = 16'd0;
                        end
                    endcase
                end
            end
        end else if (ph != PH_IDLE) begin
            refused = 1'b1;
        end else begin
            dir_pin     = dir;
            steps_left  = cnt;
            pulses_left = 8'd0;
            full_group  = 1'b0;
            if (regs.dir_setup_ticks == 16'd0) begin
                begin_group();
            end else begin
                ph       = PH_DIR;
                wait_cnt = regs.dir_setup_ticks;
            end
        end
        r.step_level     = step_pin;
        r.enable_level   = en_pin;
        r.dir_level      = dir_pin;
        r.busy_res       = (ph != PH_IDLE);
        r.start_rejected = refused;
        return r;
    endfunction

    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (!aresetn) begin
            regs        <= '{RST_MICROSTEPS_PER_STEP, RST_PULSE_HIGH_TICKS, RST_PULSE_LOW_TICKS,
                             RST_DIR_SETUP_TICKS, RST_ENABLE_LEAD_TICKS, RST_GROUP_GAP_TICKS,
                             RST_TAIL_TICKS};
            ph          <= PH_IDLE;
            wait_cnt    <= '0;
            steps_left  <= '0;
            pulses_left <= '0;
            full_group  <= 1'b0;
            step_pin    <= 1'b0;
            en_pin      <= 1'b0;
            dir_pin     <= 1'b0;
            pin_levels_q.delete();
            results_due <= 0;
            seq_busy    <= 1'b0;
            fail_count  <= mismatches;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MICROSTEPS_PER_STEP: regs.microsteps_per_step = cfg_data[7:0];
                    REG_PULSE_HIGH_TICKS:    regs.pulse_high_ticks    = cfg_data;
                    REG_PULSE_LOW_TICKS:     regs.pulse_low_ticks     = cfg_data;
                    REG_DIR_SETUP_TICKS:     regs.dir_setup_ticks     = cfg_data;
                    REG_ENABLE_LEAD_TICKS:   regs.enable_lead_ticks   = cfg_data;
                    REG_GROUP_GAP_TICKS:     regs.group_gap_ticks     = cfg_data;
                    REG_TAIL_TICKS:          regs.tail_ticks          = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                pin_levels_q.push_back(predict_pins(s_tuser, s_tdata[0], s_tdata[32:1]));
            if (m_tvalid && m_tready) begin
                got      = res_t'(m_tdata[4:0]);
                seq_busy <= got.busy_res;
                if (pin_levels_q.size() == 0) begin
                    $error("result transfer %b with no expected result", m_tdata[4:0]);
                    mismatches++;
                end else begin
                    want = pin_levels_q.pop_front();
                    for (int i = 0; i < 5; i++) begin
                        if (got[i] !== want[i]) begin
                            $error("%s: expected %0b, got %0b", res_field[i], want[i], got[i]);
                            mismatches++;
                        end
                    end
                end
            end
            results_due <= pin_levels_q.size();
            fail_count  <= mismatches;
        end
    end

endmodule

@@ dv/testbench.sv @@
// top of the stepper step pulse sequencer testbench: clock, reset, stimulus and verdict
// drives moves, ticks and register writes with random idling on both sides
// depends on ssps_pkg, stepper_step_pulse_sequencer and ssps_pin_checker
module testbench;
    import ssps_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CfgIndexWidth-1:0] REG_UNUSED = 3'd7;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [39:0]              s_tdata   = '0;    // direction, microstep_count, zero fill
    logic                     s_tuser   = 1'b0;  // opcode
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [7:0]               m_tdata;           // step_level, enable_level, dir_level,
                                                 // busy_res, start_rejected, zero fill
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CfgIndexWidth-1:0] cfg_index = '0;
    logic [CfgDataWidth-1:0]  cfg_data  = '0;

    int unsigned fail_count;
    int unsigned results_due;
    logic        seq_busy;

    logic        quiet = 1'b0;
    int unsigned ready_hold = 0;
    int unsigned busy_ticks = 0;
    cfg_t        c;
    logic [31:0] cnt;

    always #2 aclk = ~aclk;

    stepper_step_pulse_sequencer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ssps_pin_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .results_due (results_due),
        .seq_busy    (seq_busy)
    );

    // receiver stalls: mostly short, a few long, none start while quiet
    always @(posedge aclk) begin
        int unsigned r;
        r = $urandom_range(0, 99);
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (quiet || r < 60) begin
            m_tready   <= 1'b1;
            ready_hold <= $urandom_range(0, 6);
        end else if (r < 93) begin
            m_tready   <= 1'b0;
            ready_hold <= $urandom_range(0, 2);
        end else begin
            m_tready   <= 1'b0;
            ready_hold <= $urandom_range(8, 40);
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] short_ticks();
        return ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 20))
                                           : 16'($urandom_range(0, 4));
    endfunction

    // valid stays high after the transfer so back-to-back items need no toggle
    task automatic send_item(input logic op, input logic dir, input logic [31:0] count);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, count, dir};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_tick();
        send_item(OP_TICK, 1'($urandom), $urandom);
    endtask

    // refused moves follow right away, so the sequencer is still busy for them
    task automatic start_move(input logic dir, input logic [31:0] count,
                              input int unsigned refused);
        send_item(OP_MOVE, dir, count);
        repeat (refused) send_item(OP_MOVE, 1'($urandom), $urandom);
    endtask

    // tick until the latest result shows the sequencer idle and nothing is in flight
    task automatic run_until_idle();
        do begin
            while (seq_busy) begin
                send_tick();
                busy_ticks++;
            end
            s_tvalid <= 1'b0;
            do @(posedge aclk); while (results_due != 0);
        end while (seq_busy);
    endtask

    task automatic reg_write(input logic [CfgIndexWidth-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic write_regs(input cfg_t v);
        repeat (2) @(posedge aclk);
        reg_write(REG_MICROSTEPS_PER_STEP, {8'($urandom), v.microsteps_per_step});
        reg_write(REG_PULSE_HIGH_TICKS, v.pulse_high_ticks);
        reg_write(REG_PULSE_LOW_TICKS, v.pulse_low_ticks);
        reg_write(REG_DIR_SETUP_TICKS, v.dir_setup_ticks);
        reg_write(REG_ENABLE_LEAD_TICKS, v.enable_lead_ticks);
        reg_write(REG_GROUP_GAP_TICKS, v.group_gap_ticks);
        reg_write(REG_TAIL_TICKS, v.tail_ticks);
        reg_write(REG_UNUSED, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values: zero-length move with setup, then a short partial group
        start_move(1'b1, 32'd0, 1);
        run_until_idle();
        start_move(1'b0, 32'd3, 2);
        run_until_idle();

        // all zero: no waits at all, group size and pulse widths act as one
        c = '0;
        write_regs(c);
        start_move(1'b1, 32'd0, 0);
        start_move(1'b0, 32'd7, 1);
        run_until_idle();

        // largest group size, a full group and a partial one
        c = '{8'd255, 16'd1, 16'd1, 16'd1, 16'd0, 16'd3, 16'd2};
        write_regs(c);
        start_move(1'b1, 32'd260, 1);
        run_until_idle();

        // largest register values beside a short setup, run without idling
        quiet = 1'b1;
        c = '{8'd255, 16'hFFFF, 16'hFFFF, 16'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        write_regs(c);
        start_move(1'b0, 32'd0, 1);
        run_until_idle();
        quiet = 1'b0;

        busy_ticks = 0;
        while (busy_ticks < 500) begin
            quiet = ($urandom_range(0, 4) == 0);
            c.microsteps_per_step = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                                 : 8'($urandom_range(0, 6));
            c.pulse_high_ticks  = short_ticks();
            c.pulse_low_ticks   = short_ticks();
            c.dir_setup_ticks   = short_ticks();
            c.enable_lead_ticks = short_ticks();
            c.group_gap_ticks   = short_ticks();
            c.tail_ticks        = short_ticks();
            write_regs(c);
            repeat ($urandom_range(1, 4)) begin
                repeat ($urandom_range(0, 2)) send_tick();
                cnt = ($urandom_range(0, 5) == 0) ? 32'($urandom_range(0, 40))
                                                  : 32'($urandom_range(0, 10));
                start_move(1'($urandom), cnt,
                           (cnt != 0 || c.dir_setup_ticks != 0) ? $urandom_range(0, 2) : 0);
                run_until_idle();
            end
        end
        quiet = 1'b0;

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_due != 0);
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && results_due == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
